/* rtl/core/cfp_pkg.sv */
// Shared types and constants of the command frame parser.
package cfp_pkg;

	localparam int unsigned CountW = 17;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned OutDataW = 88;

	localparam logic [7:0] HDR_FIRST = 8'h4C;
	localparam logic [7:0] HDR_SECOND = 8'h54;
	localparam logic [CountW-1:0] FIXED_BYTES = CountW'(7);
	localparam logic [CountW-1:0] STAMP_BYTES = CountW'(4);
	localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

	localparam logic [CountW-1:0] POS_HDR0 = CountW'(0);
	localparam logic [CountW-1:0] POS_HDR1 = CountW'(1);
	localparam logic [CountW-1:0] POS_CLI_HI = CountW'(2);
	localparam logic [CountW-1:0] POS_CLI_LO = CountW'(3);
	localparam logic [CountW-1:0] POS_REQ = CountW'(4);
	localparam logic [CountW-1:0] POS_LEN_HI = CountW'(5);
	localparam logic [CountW-1:0] POS_LEN_LO = CountW'(6);

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_SHORT = 3'd1,
		ST_HEADER = 3'd2,
		ST_CLIENT = 3'd3,
		ST_REQUEST = 3'd4,
		ST_LENGTH = 3'd5
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CLIENT_A = 3'd0,
		REG_CLIENT_B = 3'd1,
		REG_REQUEST_A = 3'd2,
		REG_REQUEST_B = 3'd3,
		REG_REQUEST_C = 3'd4,
		REG_MIN_FRAME = 3'd5,
		REG_MAX_PAYLOAD = 3'd6,
		REG_UNUSED = 3'd7
	} reg_idx_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] payload_byte;
		status_t status;
		logic [15:0] client_code;
		logic [7:0] request_code;
		logic [15:0] payload_length;
		logic [31:0] stamp;
		logic final_res;
	} result_t;

endpackage

/* rtl/core/command_frame_parser.sv */
// Command frame parser: byte stream in, payload bytes and frame status out.
//
// channel  dir  handshake                  contents
// s_axis   in   s_tvalid/s_tready          s_tdata = data_byte, s_tlast = last_byte
// m_axis   out  m_tvalid/m_tready          m_tuser = kind, m_tlast = final_res, m_tdata fields
// cfg      in   cfg_we                     cfg_index selects register, cfg_data value
//
// One byte per cycle unless a stall on m_tready holds it; a last byte that is also a payload
// byte gives two results, as the single output register carries one result per cycle.
// Bytes pass an input register, then the frame checks, then the output register.
// arst_n clears the control state and the frame state and sets the configuration to its reset values.
// A stall on m_tready backs up into s_tready through the one-entry input stage.
module command_frame_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] data_byte
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [7:0] payload_byte, [10:8] status, [26:11] client_code, [34:27] request_code,
	// [50:35] payload_length, [82:51] stamp, [87:83] zero
	output logic [cfp_pkg::OutDataW-1:0] m_tdata,
	output logic                         m_tuser,  // [0] kind
	output logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [cfp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [cfp_pkg::CfgDataW-1:0] cfg_data
);

	logic [15:0] client_a_q, client_b_q, min_frame_q, max_payload_q;
	logic [7:0] request_a_q, request_b_q, request_c_q;

	logic s1_valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic pay_sent_q;

	logic [cfp_pkg::CountW-1:0] count_q;
	logic hdr_bad_q;
	logic [15:0] client_q, length_q;
	logic [7:0] request_q;
	logic [31:0] tail_q;

	logic out_valid_q;
	cfp_pkg::result_t out_q;

	logic [cfp_pkg::CountW-1:0] count_new;
	logic hdr_bad_new;
	logic [15:0] client_new, length_new;
	logic [7:0] request_new;
	logic [31:0] tail_new;
	logic is_payload, out_load, emit, s1_done;
	cfp_pkg::result_t res;
	cfp_pkg::status_t status_new;
	logic [cfp_pkg::CountW-1:0] pay_end, frame_len;

	always_comb begin
		count_new = (count_q == cfp_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
		tail_new = {tail_q[23:0], byte_s1};
		hdr_bad_new = hdr_bad_q;
		client_new = client_q;
		request_new = request_q;
		length_new = length_q;
		unique case (count_q)
			cfp_pkg::POS_HDR0: hdr_bad_new = (byte_s1 != cfp_pkg::HDR_FIRST);
			cfp_pkg::POS_HDR1: hdr_bad_new = hdr_bad_q | (byte_s1 != cfp_pkg::HDR_SECOND);
			cfp_pkg::POS_CLI_HI: client_new = {byte_s1, 8'h00};
			cfp_pkg::POS_CLI_LO: client_new = {client_q[15:8], byte_s1};
			cfp_pkg::POS_REQ: request_new = byte_s1;
			cfp_pkg::POS_LEN_HI: length_new = {byte_s1, 8'h00};
			cfp_pkg::POS_LEN_LO: length_new = {length_q[15:8], byte_s1};
			default: ;
		endcase
	end

	assign pay_end = cfp_pkg::FIXED_BYTES + cfp_pkg::CountW'(length_q);
	assign is_payload = (count_q >= cfp_pkg::FIXED_BYTES) && (count_q < pay_end);
	assign frame_len = cfp_pkg::FIXED_BYTES + cfp_pkg::CountW'(length_new)
		+ cfp_pkg::STAMP_BYTES;

	always_comb begin
		priority if (count_new < cfp_pkg::CountW'(min_frame_q)) begin
			status_new = cfp_pkg::ST_SHORT;
		end else if (count_new < cfp_pkg::CountW'(2) || hdr_bad_new) begin
			status_new = cfp_pkg::ST_HEADER;
		end else if (client_new != client_a_q && client_new != client_b_q) begin
			status_new = cfp_pkg::ST_CLIENT;
		end else if (request_new != request_a_q && request_new != request_b_q
				&& request_new != request_c_q) begin
			status_new = cfp_pkg::ST_REQUEST;
		end else if (count_new != frame_len || length_new > max_payload_q) begin
			status_new = cfp_pkg::ST_LENGTH;
		end else begin
			status_new = cfp_pkg::ST_OK;
		end
	end

	always_comb begin
		res = '0;
		if (is_payload && !pay_sent_q) begin
			res.kind = cfp_pkg::KIND_PAYLOAD;
			res.payload_byte = byte_s1;
			res.final_res = !last_s1;
		end else begin
			res.kind = cfp_pkg::KIND_STATUS;
			res.status = status_new;
			res.final_res = 1'b1;
			if (status_new == cfp_pkg::ST_OK || status_new == cfp_pkg::ST_CLIENT
					|| status_new == cfp_pkg::ST_REQUEST
					|| status_new == cfp_pkg::ST_LENGTH) begin
				res.client_code = client_new;
			end
			if (status_new == cfp_pkg::ST_OK || status_new == cfp_pkg::ST_REQUEST
					|| status_new == cfp_pkg::ST_LENGTH) begin
				res.request_code = request_new;
			end
			if (status_new == cfp_pkg::ST_OK || status_new == cfp_pkg::ST_LENGTH) begin
				res.payload_length = length_new;
			end
			if (status_new == cfp_pkg::ST_OK) begin
				res.stamp = tail_new;
			end
		end
	end

	assign out_load = !out_valid_q || m_tready;
	assign emit = s1_valid_s1 && out_load && ((is_payload && !pay_sent_q) || last_s1);
	// done unless the output is stalled for a result or the payload result of a last byte has just gone out
	assign s1_done = s1_valid_s1 && (
		(!(is_payload && !pay_sent_q) && !last_s1) ||
		(out_load && !(is_payload && !pay_sent_q && last_s1)));
	assign s_tready = !s1_valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_a_q <= '0;
			client_b_q <= '0;
			request_a_q <= '0;
			request_b_q <= '0;
			request_c_q <= '0;
			min_frame_q <= 16'd11;
			max_payload_q <= 16'd512;
		end else if (cfg_we) begin
			unique case (cfp_pkg::reg_idx_t'(cfg_index))
				cfp_pkg::REG_CLIENT_A: client_a_q <= cfg_data;
				cfp_pkg::REG_CLIENT_B: client_b_q <= cfg_data;
				cfp_pkg::REG_REQUEST_A: request_a_q <= cfg_data[7:0];
				cfp_pkg::REG_REQUEST_B: request_b_q <= cfg_data[7:0];
				cfp_pkg::REG_REQUEST_C: request_c_q <= cfg_data[7:0];
				cfp_pkg::REG_MIN_FRAME: min_frame_q <= cfg_data;
				cfp_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			pay_sent_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_s1 <= s_tvalid;
			end
			if (s1_done) begin
				pay_sent_q <= 1'b0;
			end else if (emit) begin
				pay_sent_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hdr_bad_q <= 1'b0;
			client_q <= '0;
			request_q <= '0;
			length_q <= '0;
			tail_q <= '0;
		end else if (s1_done) begin
			if (last_s1) begin
				count_q <= '0;
				hdr_bad_q <= 1'b0;
				client_q <= '0;
				request_q <= '0;
				length_q <= '0;
				tail_q <= '0;
			end else begin
				count_q <= count_new;
				hdr_bad_q <= hdr_bad_new;
				client_q <= client_new;
				request_q <= request_new;
				length_q <= length_new;
				tail_q <= tail_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.kind;
	assign m_tlast = out_q.final_res;
	assign m_tdata = {5'b0, out_q.stamp, out_q.payload_length, out_q.request_code,
		out_q.client_code, out_q.status, out_q.payload_byte};

	a_pay_sent_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pay_sent_q |-> s1_valid_s1 && last_s1) else $error("payload flag without item");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cfp_pkg::KIND_PAYLOAD |->
			out_q.status == cfp_pkg::ST_OK && out_q.stamp == '0)
		else $error("payload result carries status fields");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cfp_pkg::KIND_STATUS |-> m_tlast)
		else $error("status result not final");

	a_stamp_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.status != cfp_pkg::ST_OK |-> out_q.stamp == '0)
		else $error("stamp reported on failed frame");

	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !s1_done |=> s1_valid_s1 && pay_sent_q)
		else $error("status of a payload last byte lost");

endmodule

/* sim/command_frame_parser_tb.sv */
// Self-checking testbench for command_frame_parser: directed and random frames, payload and status checks.
module command_frame_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [7:0]                    s_tdata;
	logic                          s_tlast;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [cfp_pkg::OutDataW-1:0]  m_tdata;
	logic                          m_tuser;
	logic                          m_tlast;
	logic                          cfg_we;
	logic [cfp_pkg::CfgIdxW-1:0]   cfg_index;
	logic [cfp_pkg::CfgDataW-1:0]  cfg_data;

	command_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	frame_byte_t       frame_byte_q[$];
	cfp_pkg::result_t  parsed_q[$];
	frame_byte_t       next_byte;
	cfp_pkg::result_t  got;
	cfp_pkg::result_t  want;
	logic              field_bad;
	int                bytes_queued;
	int                bytes_taken;
	int                fault_cnt;
	int                tx_idle_pct;
	int                rx_idle_pct;

	// accepted codes and limits as last written
	logic [15:0] acc_client_a, acc_client_b;
	logic [7:0]  acc_req_a, acc_req_b, acc_req_c;
	logic [15:0] min_frame_len, max_payload_len;

	// frame being parsed
	logic [cfp_pkg::CountW-1:0] frm_count;
	logic                       frm_hdr_bad;
	logic [15:0]                frm_client;
	logic [7:0]                 frm_request;
	logic [15:0]                frm_length;
	logic [31:0]                frm_tail;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL command_frame_parser");
		$finish;
	end

	function automatic string fmt_result(input cfp_pkg::result_t r);
		return $sformatf(
			"kind=%0d byte=%02h st=%0d cli=%04h req=%02h len=%04h stamp=%08h fin=%0d",
			r.kind, r.payload_byte, r.status, r.client_code, r.request_code,
			r.payload_length, r.stamp, r.final_res);
	endfunction

	task automatic parse_frame_byte(input logic [7:0] b, input logic last);
		cfp_pkg::result_t           r;
		logic [cfp_pkg::CountW-1:0] pos;
		pos = frm_count;
		if (frm_count != cfp_pkg::COUNT_MAX)
			frm_count = frm_count + 1'b1;
		frm_tail = {frm_tail[23:0], b};
		case (pos)
			cfp_pkg::POS_HDR0: frm_hdr_bad = (b != cfp_pkg::HDR_FIRST);
			cfp_pkg::POS_HDR1: frm_hdr_bad = frm_hdr_bad || (b != cfp_pkg::HDR_SECOND);
			cfp_pkg::POS_CLI_HI: frm_client = {b, 8'h00};
			cfp_pkg::POS_CLI_LO: frm_client[7:0] = b;
			cfp_pkg::POS_REQ: frm_request = b;
			cfp_pkg::POS_LEN_HI: frm_length = {b, 8'h00};
			cfp_pkg::POS_LEN_LO: frm_length[7:0] = b;
			default: ;
		endcase
		if (pos >= cfp_pkg::FIXED_BYTES &&
			int'(pos) < int'(cfp_pkg::FIXED_BYTES) + int'(frm_length)) begin
			r = '0;
			r.kind = cfp_pkg::KIND_PAYLOAD;
			r.payload_byte = b;
			r.final_res = !last;
			parsed_q.push_back(r);
		end
		if (last) begin
			r = '0;
			r.kind = cfp_pkg::KIND_STATUS;
			r.final_res = 1'b1;
			if (int'(frm_count) < int'(min_frame_len)) begin
				r.status = cfp_pkg::ST_SHORT;
			end else if (int'(frm_count) < 2 || frm_hdr_bad) begin
				r.status = cfp_pkg::ST_HEADER;
			end else if (frm_client != acc_client_a && frm_client != acc_client_b) begin
				r.status = cfp_pkg::ST_CLIENT;
				r.client_code = frm_client;
			end else if (frm_request != acc_req_a && frm_request != acc_req_b &&
				frm_request != acc_req_c) begin
				r.status = cfp_pkg::ST_REQUEST;
				r.client_code = frm_client;
				r.request_code = frm_request;
			end else if (int'(frm_count) != int'(cfp_pkg::FIXED_BYTES) + int'(frm_length)
				+ int'(cfp_pkg::STAMP_BYTES) || frm_length > max_payload_len) begin
				r.status = cfp_pkg::ST_LENGTH;
				r.client_code = frm_client;
				r.request_code = frm_request;
				r.payload_length = frm_length;
			end else begin
				r.status = cfp_pkg::ST_OK;
				r.client_code = frm_client;
				r.request_code = frm_request;
				r.payload_length = frm_length;
				r.stamp = frm_tail;
			end
			parsed_q.push_back(r);
			frm_count = '0;
			frm_hdr_bad = 1'b0;
			frm_client = '0;
			frm_request = '0;
			frm_length = '0;
			frm_tail = '0;
		end
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (frame_byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_byte = frame_byte_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_byte.data;
				s_tlast <= next_byte.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			parse_frame_byte(s_tdata, s_tlast);
			bytes_taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = cfp_pkg::kind_t'(m_tuser);
			got.payload_byte = m_tdata[7:0];
			got.status = cfp_pkg::status_t'(m_tdata[10:8]);
			got.client_code = m_tdata[26:11];
			got.request_code = m_tdata[34:27];
			got.payload_length = m_tdata[50:35];
			got.stamp = m_tdata[82:51];
			got.final_res = m_tlast;
			if (parsed_q.size() == 0) begin
				if (fault_cnt < 10)
					$display("unexpected transfer at %0t: %s", $time, fmt_result(got));
				fault_cnt++;
			end else begin
				want = parsed_q.pop_front();
				field_bad = (got.kind !== want.kind) ||
					(got.payload_byte !== want.payload_byte) ||
					(got.status !== want.status) ||
					(got.client_code !== want.client_code) ||
					(got.request_code !== want.request_code) ||
					(got.payload_length !== want.payload_length) ||
					(got.stamp !== want.stamp) ||
					(got.final_res !== want.final_res);
				if (field_bad) begin
					if (fault_cnt < 10)
						$display("mismatch at %0t: expected %s, got %s", $time,
							fmt_result(want), fmt_result(got));
					fault_cnt++;
				end
			end
		end
	end

	task automatic write_reg(input cfp_pkg::reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cfp_pkg::REG_CLIENT_A: acc_client_a = val;
			cfp_pkg::REG_CLIENT_B: acc_client_b = val;
			cfp_pkg::REG_REQUEST_A: acc_req_a = val[7:0];
			cfp_pkg::REG_REQUEST_B: acc_req_b = val[7:0];
			cfp_pkg::REG_REQUEST_C: acc_req_c = val[7:0];
			cfp_pkg::REG_MIN_FRAME: min_frame_len = val;
			cfp_pkg::REG_MAX_PAYLOAD: max_payload_len = val;
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [15:0] cli_a, input logic [15:0] cli_b,
		input logic [7:0] req_a, input logic [7:0] req_b, input logic [7:0] req_c,
		input logic [15:0] min_len, input logic [15:0] max_len);
		write_reg(cfp_pkg::REG_CLIENT_A, cli_a);
		write_reg(cfp_pkg::REG_CLIENT_B, cli_b);
		write_reg(cfp_pkg::REG_REQUEST_A, {8'h00, req_a});
		write_reg(cfp_pkg::REG_REQUEST_B, {8'h00, req_b});
		write_reg(cfp_pkg::REG_REQUEST_C, {8'h00, req_c});
		write_reg(cfp_pkg::REG_MIN_FRAME, min_len);
		write_reg(cfp_pkg::REG_MAX_PAYLOAD, max_len);
		// unused index must be ignored
		write_reg(cfp_pkg::REG_UNUSED, 16'($urandom_range(16'hFFFF)));
	endtask

	task automatic add_frame(input logic [7:0] fr[$]);
		foreach (fr[i]) begin
			frame_byte_q.push_back('{data: fr[i], last: (i == fr.size() - 1)});
			bytes_queued++;
		end
	endtask

	task automatic add_random_frame();
		logic [7:0]  fr[$];
		logic [15:0] cli;
		logic [15:0] len;
		logic [7:0]  req;
		int          sel;
		int          pay_n;
		int          trim;
		sel = $urandom_range(99);
		cli = $urandom_range(1) ? acc_client_a : acc_client_b;
		case ($urandom_range(2))
			0: req = acc_req_a;
			1: req = acc_req_b;
			default: req = acc_req_c;
		endcase
		if (sel < 8 && max_payload_len < 60)
			len = max_payload_len + 16'($urandom_range(1));
		else if ($urandom_range(2) == 0)
			len = 16'd0;
		else
			len = 16'($urandom_range(12, 1));
		pay_n = len;
		if (sel >= 60 && sel < 70)
			cli = 16'($urandom_range(16'hFFFF));
		if (sel >= 70 && sel < 78)
			req = 8'($urandom_range(255));
		if (sel >= 86 && sel < 90) begin
			// large length, frame cut inside the payload
			len = 16'($urandom_range(16'hFFFF));
			pay_n = $urandom_range(12);
		end
		fr = '{cfp_pkg::HDR_FIRST, cfp_pkg::HDR_SECOND, cli[15:8], cli[7:0], req,
			len[15:8], len[7:0]};
		repeat (pay_n) fr.push_back(8'($urandom_range(255)));
		if (!(sel >= 86 && sel < 90))
			repeat (4) fr.push_back(8'($urandom_range(255)));
		if (sel >= 78 && sel < 86)
			fr[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
		if (sel >= 90 && sel < 94) begin
			if ($urandom_range(1)) begin
				trim = $urandom_range(5, 1);
				repeat (trim) void'(fr.pop_back());
			end else begin
				repeat ($urandom_range(5, 1)) fr.push_back(8'($urandom_range(255)));
			end
		end
		if (sel >= 94) begin
			fr.delete();
			repeat ($urandom_range(20, 1)) fr.push_back(8'($urandom_range(255)));
		end
		add_frame(fr);
	endtask

	task automatic queue_random_frames(input int n_bytes);
		int start;
		start = bytes_queued;
		while (bytes_queued - start < n_bytes)
			add_random_frame();
	endtask

	task automatic wait_idle();
		while (bytes_taken != bytes_queued || parsed_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [7:0] fr[$];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bytes_queued = 0;
		bytes_taken = 0;
		fault_cnt = 0;
		tx_idle_pct = 27;
		rx_idle_pct = 77;
		acc_client_a = '0;
		acc_client_b = '0;
		acc_req_a = '0;
		acc_req_b = '0;
		acc_req_c = '0;
		min_frame_len = 16'd11;
		max_payload_len = 16'd512;
		frm_count = '0;
		frm_hdr_bad = 1'b0;
		frm_client = '0;
		frm_request = '0;
		frm_length = '0;
		frm_tail = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames on reset settings: good empty frame, one byte, cut payload
		fr = '{8'h4C, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A};
		add_frame(fr);
		fr = '{8'hFF};
		add_frame(fr);
		fr = '{8'h4C, 8'h54, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hAB};
		add_frame(fr);
		wait_idle();

		load_config(16'($urandom_range(16'hFFFF)), 16'hFFFF, 8'h00, 8'hFF,
			8'($urandom_range(255)), 16'd11, 16'd8);
		queue_random_frames(420);
		wait_idle();

		tx_idle_pct = 77;
		rx_idle_pct = 27;
		load_config(16'h0000, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 16'd7, 16'd0);
		queue_random_frames(420);
		wait_idle();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			16'hFFFF, 16'hFFFF);
		queue_random_frames(40);
		wait_idle();

		load_config(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			16'd15, 16'hFFFF);
		queue_random_frames(370);
		wait_idle();

		fault_cnt += parsed_q.size();
		if (fault_cnt == 0)
			$display("PASS command_frame_parser");
		else
			$display("FAIL command_frame_parser");
		$finish;
	end

endmodule
